// ===== hw/rtl/pal_pkg.sv =====
// shared constants and types for the positional array list
package pal_pkg;

	localparam int DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int PAY_W = 32;
	localparam int POS_W = 7;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_SEARCH = 2'd3;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/pal_cell.sv =====
// one list slot: holds a key and payload, shifts with its neighbors, compares its key
module pal_cell (
	input  logic                      clk,
	input  logic [pal_pkg::IDX_W-1:0] cell_index,
	input  pal_pkg::cell_ctl_t        ctl,
	input  logic [pal_pkg::KEY_W-1:0] new_key,
	input  logic [pal_pkg::PAY_W-1:0] new_payload,
	input  logic [pal_pkg::KEY_W-1:0] left_key,
	input  logic [pal_pkg::PAY_W-1:0] left_payload,
	input  logic [pal_pkg::KEY_W-1:0] right_key,
	input  logic [pal_pkg::PAY_W-1:0] right_payload,
	input  logic [pal_pkg::KEY_W-1:0] find_key,
	output logic [pal_pkg::KEY_W-1:0] key_out,
	output logic [pal_pkg::PAY_W-1:0] payload_out,
	output logic                      hit
);
	import pal_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] payload_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (cell_index == ctl.idx) begin
				key_q     <= new_key;
				payload_q <= new_payload;
			end else if (cell_index > ctl.idx) begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end
		end else if (ctl.rem) begin
			if (cell_index >= ctl.idx) begin
				key_q     <= right_key;
				payload_q <= right_payload;
			end
		end
	end

	assign key_out     = key_q;
	assign payload_out = payload_q;
	assign hit         = (key_q == find_key);

endmodule

// ===== hw/rtl/pal_chain.sv =====
// row of list cells wired to their neighbors, with the occupied-entry hit vector
module pal_chain (
	input  logic                      clk,
	input  pal_pkg::cell_ctl_t        ctl,
	input  logic [pal_pkg::KEY_W-1:0] new_key,
	input  logic [pal_pkg::PAY_W-1:0] new_payload,
	input  logic [pal_pkg::KEY_W-1:0] find_key,
	input  logic [pal_pkg::CNT_W-1:0] count,
	output logic [pal_pkg::DEPTH-1:0] hits
);
	import pal_pkg::*;

	logic [KEY_W-1:0] key_v [DEPTH];
	logic [PAY_W-1:0] pay_v [DEPTH];
	logic [DEPTH-1:0] raw_hit;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] lk, rk;
		logic [PAY_W-1:0] lp, rp;

		if (i == 0) begin : g_first
			assign lk = new_key;
			assign lp = new_payload;
		end else begin : g_mid
			assign lk = key_v[i-1];
			assign lp = pay_v[i-1];
		end

		// last cell keeps its own contents on a remove
		if (i == DEPTH - 1) begin : g_last
			assign rk = key_v[i];
			assign rp = pay_v[i];
		end else begin : g_inner
			assign rk = key_v[i+1];
			assign rp = pay_v[i+1];
		end

		pal_cell u_cell (
			.clk           (clk),
			.cell_index    (IDX_W'(i)),
			.ctl           (ctl),
			.new_key       (new_key),
			.new_payload   (new_payload),
			.left_key      (lk),
			.left_payload  (lp),
			.right_key     (rk),
			.right_payload (rp),
			.find_key      (find_key),
			.key_out       (key_v[i]),
			.payload_out   (pay_v[i]),
			.hit           (raw_hit[i])
		);

		// only occupied slots take part in a search
		assign hits[i] = raw_hit[i] && (int'(count) > i);
	end

endmodule

// ===== hw/rtl/pal_first_hit.sv =====
// one-based position of the lowest set bit of the hit vector, zero when none
module pal_first_hit (
	input  logic [pal_pkg::DEPTH-1:0] hits,
	output logic [pal_pkg::CNT_W-1:0] first_pos
);
	import pal_pkg::*;

	logic [DEPTH-1:0] lowest;

	assign lowest = hits & (~hits + DEPTH'(1));

	always_comb begin
		first_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lowest[i]) begin
				first_pos = first_pos | CNT_W'(i + 1);
			end
		end
	end

endmodule

// ===== hw/rtl/positional_array_list.sv =====
// top level of the positional array list: action decode, cell chain, result stages
//
// channel | signals                                         | handshake
// in      | action, entry_key, entry_payload, position      | in_valid / in_ready
// out     | ok, found_position, entry_count                 | out_valid / out_ready
//
// one transaction per cycle sustained while the output does not stall; the cell
// chain shifts entries from the operated position on and compares all keys in the
// cycle a transaction is taken; a result passes the hit vector register, then the
// output register holding the first-hit position
// reset clears the entry count and the stage valids; cell contents are not reset
// a stalled output holds the stages and in_ready drops once both are full
module positional_array_list (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [pal_pkg::KEY_W-1:0]   entry_key,
	input  logic [pal_pkg::PAY_W-1:0]   entry_payload,
	input  logic [pal_pkg::POS_W-1:0]   position,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        ok,
	output logic [pal_pkg::POS_W-1:0]   found_position,
	output logic [pal_pkg::POS_W-1:0]   entry_count
);
	import pal_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             advance;
	logic             do_ins, do_rem;
	logic [IDX_W-1:0] op_idx;
	logic [POS_W-1:0] pos_m1;
	logic [CNT_W-1:0] count_nxt;
	cell_ctl_t        ctl;
	logic [DEPTH-1:0] hits;
	logic [CNT_W-1:0] first_pos;

	logic             valid_s1;
	logic             search_s1;
	logic             ok_s1;
	logic [CNT_W-1:0] count_s1;
	logic [DEPTH-1:0] hits_s1;

	logic             out_valid_q;
	logic             ok_q;
	logic [CNT_W-1:0] found_q;
	logic [CNT_W-1:0] cnt_q;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign pos_m1   = position - POS_W'(1);

	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		op_idx = count_q[IDX_W-1:0];
		unique case (action)
			ACT_APPEND: begin
				do_ins = (int'(count_q) < DEPTH);
			end
			ACT_INSERT: begin
				do_ins = (int'(count_q) < DEPTH) && (position != '0)
					&& (int'(position) <= DEPTH);
				// a position past the count appends
				if (int'(pos_m1) < int'(count_q)) begin
					op_idx = IDX_W'(pos_m1);
				end
			end
			ACT_REMOVE: begin
				do_rem = (count_q != '0) && (position != '0)
					&& (int'(position) <= int'(count_q));
				op_idx = IDX_W'(pos_m1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign ctl.ins = accept && do_ins;
	assign ctl.rem = accept && do_rem;
	assign ctl.idx = op_idx;

	pal_chain u_chain (
		.clk         (clk),
		.ctl         (ctl),
		.new_key     (entry_key),
		.new_payload (entry_payload),
		.find_key    (entry_key),
		.count       (count_q),
		.hits        (hits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			search_s1 <= (action == ACT_SEARCH);
			ok_s1     <= do_ins || do_rem;
			count_s1  <= count_nxt;
			hits_s1   <= hits;
		end
	end

	pal_first_hit u_first_hit (
		.hits      (hits_s1),
		.first_pos (first_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			ok_q    <= search_s1 ? (|hits_s1) : ok_s1;
			found_q <= search_s1 ? first_pos : '0;
			cnt_q   <= count_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign ok             = ok_q;
	assign found_position = POS_W'(found_q);
	assign entry_count    = POS_W'(cnt_q);

endmodule
